// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the segment point subdivider.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off while in reset.
`define SPS_ASSERT_IMPL(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked on the rising clock, off while in reset.
`define SPS_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

// ----- design/sps_pkg.sv -----
// Shared constants, types and controller/datapath command/status structs of the
// segment point subdivider. No dependencies.
`default_nettype none

package sps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  // Sequencing lengths of the iterative units
  localparam int SQ_STEPS = 33;  // shift-add squaring, one multiplier bit a cycle
  localparam int RT_STEPS = 34;  // square root, one root bit a cycle
  localparam int DV_STEPS = 34;  // restoring division, one quotient bit a cycle

  typedef enum logic [1:0] {
    DV_N,
    DV_X,
    DV_Y
  } dv_sel_e;

  typedef struct packed {
    logic    load;
    logic    sq_step;
    logic    rt_step;
    logic    dv_start;
    logic    dv_step;
    logic    dv_done;
    dv_sel_e dv_sel;
    logic    pt_emit;
  } sps_cmd_t;

  typedef struct packed {
    logic zero_seg;
    logic quo_zero;
    logic out_free;
    logic last_pt;
  } sps_sts_t;

endpackage

`default_nettype wire

// ----- design/sps_seg_if.sv -----
// Segment input channel: valid/ready plus the four Q16.16 coordinates.
// No dependencies.
`default_nettype none

interface sps_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_start;
  logic signed [31:0] y_start;
  logic signed [31:0] x_end;
  logic signed [31:0] y_end;

  modport source (output valid, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

`default_nettype wire

// ----- design/sps_pt_if.sv -----
// Point output channel: valid/ready plus one subdivided point per beat.
// No dependencies.
`default_nettype none

interface sps_pt_if;
  logic               valid;
  logic               ready;
  logic signed [22:0] x_hundredths;
  logic signed [22:0] y_hundredths;
  logic        [5:0]  point_index;
  logic               last;
  logic               status;

  modport source (output valid, x_hundredths, y_hundredths, point_index, last, status,
                  input ready);
  modport sink   (input valid, x_hundredths, y_hundredths, point_index, last, status,
                  output ready);
endinterface

`default_nettype wire

// ----- design/sps_cfg_if.sv -----
// Configuration write channel: valid/ready plus the pitch write data.
// No dependencies.
`default_nettype none

interface sps_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/sps_ctrl.sv -----
// Controller state machine of the segment point subdivider.
// Depends on sps_pkg for the sequencing lengths and command/status structs.
`default_nettype none

module sps_ctrl import sps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sps_sts_t sts_i,
  output sps_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_DIVX = 3'd4;
  localparam logic [2:0] S_DIVY = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.dv_sel = DV_N;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.zero_seg) begin
            state_d = S_SQR;
            cnt_d   = '0;
          end
        end
      end
      S_SQR: begin
        cmd_o.sq_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SQ_STEPS - 1)) begin
          state_d = S_ROOT;
          cnt_d   = '0;
        end
      end
      S_ROOT: begin
        cmd_o.rt_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(RT_STEPS - 1)) begin
          state_d = S_DIVN;
          cnt_d   = '0;
        end
      end
      S_DIVN, S_DIVX, S_DIVY: begin
        if (state_q == S_DIVX) begin
          cmd_o.dv_sel = DV_X;
        end else if (state_q == S_DIVY) begin
          cmd_o.dv_sel = DV_Y;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == '0) begin
          cmd_o.dv_start = 1'b1;
        end else if (cnt_q <= 6'(DV_STEPS)) begin
          cmd_o.dv_step = 1'b1;
        end else begin
          cmd_o.dv_done = 1'b1;
          cnt_d = '0;
          if (state_q == S_DIVN) begin
            // a zero count has no per-point increment to work out
            state_d = sts_i.quo_zero ? S_EMIT : S_DIVX;
          end else if (state_q == S_DIVX) begin
            state_d = S_DIVY;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.pt_emit = 1'b1;
          if (sts_i.last_pt) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/sps_dp.sv -----
// Datapath of the segment point subdivider: squaring, root, divider,
// point stepper, pitch register and output register. Depends on sps_pkg.
`default_nettype none

module sps_dp import sps_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [31:0] x_start_i,
  input  wire logic signed [31:0] y_start_i,
  input  wire logic signed [31:0] x_end_i,
  input  wire logic signed [31:0] y_end_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire sps_cmd_t           cmd_i,
  output sps_sts_t                sts_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic signed [22:0]      x_hundredths_o,
  output logic signed [22:0]      y_hundredths_o,
  output logic [5:0]              point_index_o,
  output logic                    last_o,
  output logic                    status_o
);

  logic [30:0]        pitch_q;
  logic signed [31:0] xs_q, ys_q;
  logic               dx_neg_q, dy_neg_q;
  logic [32:0]        adx_q, ady_q, mx_q, my_q;
  logic [66:0]        sx_q, sy_q;
  logic [67:0]        sum_q;
  logic [35:0]        rem_q;
  logic [33:0]        root_q;
  logic [33:0]        dv_rem_q, dv_quo_q, dv_den_q;
  logic [33:0]        n_q;
  logic signed [33:0] qdx_q, qdy_q, qax_q, qay_q;
  logic [33:0]        rdx_q, rdy_q, rax_q, ray_q;
  logic [IDX_W-1:0]   idx_q;
  logic               cut_q;
  logic               out_valid_q;
  logic signed [22:0] xh_q, yh_q;
  logic [5:0]         pidx_q;
  logic               last_q, status_q;

  // Segment differences and magnitudes
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  assign dx  = 33'($signed(x_end_i)) - 33'($signed(x_start_i));
  assign dy  = 33'($signed(y_end_i)) - 33'($signed(y_start_i));
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  // Squaring: add shifted multiplicands selected by the low multiplier bits
  logic [67:0] sum_d;
  assign sum_d = sum_q + (mx_q[0] ? {1'b0, sx_q} : 68'd0) + (my_q[0] ? {1'b0, sy_q} : 68'd0);

  // Root: one bit per step from the top two radicand bits
  logic [36:0] rt_sh, rt_trial;
  logic        rt_ge;
  assign rt_sh    = {rem_q[34:0], sum_q[67:66]};
  assign rt_trial = {1'b0, root_q, 2'b01};
  assign rt_ge    = rt_sh >= rt_trial;

  // Divider: restoring, one quotient bit per step
  logic [34:0] dv_t;
  logic        dv_ge;
  assign dv_t  = {dv_rem_q, dv_quo_q[33]};
  assign dv_ge = dv_t >= {1'b0, dv_den_q};

  // Signed floor quotient and remainder from the magnitude division
  logic signed [33:0] fq;
  logic [33:0]        fr;
  logic               fneg;
  always_comb begin
    fneg = (cmd_i.dv_sel == DV_X) ? dx_neg_q : dy_neg_q;
    if (fneg && dv_rem_q != '0) begin
      fq = -$signed(dv_quo_q) - 34'sd1;
      fr = n_q - dv_rem_q;
    end else begin
      fq = fneg ? -$signed(dv_quo_q) : $signed(dv_quo_q);
      fr = dv_rem_q;
    end
  end

  // Point stepper: running floor(i*d/n) with remainder in [0, n)
  logic [34:0] tx, ty;
  logic        wx, wy;
  assign tx = {1'b0, rax_q} + {1'b0, rdx_q};
  assign ty = {1'b0, ray_q} + {1'b0, rdy_q};
  assign wx = tx >= {1'b0, n_q};
  assign wy = ty >= {1'b0, n_q};

  // Point coordinates and hundredths
  logic signed [33:0] px, py;
  logic signed [39:0] hx, hy;
  assign px = 34'(xs_q) + qax_q;
  assign py = 34'(ys_q) + qay_q;
  assign hx = 40'($signed(px[31:0])) * 40'sd100;
  assign hy = 40'($signed(py[31:0])) * 40'sd100;

  assign sts_o.zero_seg = (x_start_i == '0) && (y_start_i == '0)
                          && (x_end_i == '0) && (y_end_i == '0);
  assign sts_o.quo_zero = (dv_quo_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last_pt  = cut_q ? (idx_q == IDX_W'(MAX_POINTS - 1))
                                : (34'(idx_q) == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q     <= 31'd65536;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pitch_q <= cfg_data_i;
      end
      if (cmd_i.pt_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xs_q     <= x_start_i;
      ys_q     <= y_start_i;
      dx_neg_q <= dx[32];
      dy_neg_q <= dy[32];
      adx_q    <= adx;
      ady_q    <= ady;
      mx_q     <= adx;
      my_q     <= ady;
      sx_q     <= 67'(adx);
      sy_q     <= 67'(ady);
      sum_q    <= '0;
      rem_q    <= '0;
      root_q   <= '0;
    end
    if (cmd_i.sq_step) begin
      sum_q <= sum_d;
      sx_q  <= {sx_q[65:0], 1'b0};
      sy_q  <= {sy_q[65:0], 1'b0};
      mx_q  <= {1'b0, mx_q[32:1]};
      my_q  <= {1'b0, my_q[32:1]};
    end
    if (cmd_i.rt_step) begin
      sum_q  <= {sum_q[65:0], 2'b00};
      rem_q  <= rt_ge ? 36'(rt_sh - rt_trial) : rt_sh[35:0];
      root_q <= {root_q[32:0], rt_ge};
    end
    if (cmd_i.dv_start) begin
      dv_rem_q <= '0;
      case (cmd_i.dv_sel)
        DV_N: begin
          dv_quo_q <= root_q;
          dv_den_q <= (pitch_q == '0) ? 34'd1 : 34'(pitch_q);
        end
        DV_X: begin
          dv_quo_q <= 34'(adx_q);
          dv_den_q <= n_q;
        end
        default: begin
          dv_quo_q <= 34'(ady_q);
          dv_den_q <= n_q;
        end
      endcase
    end
    if (cmd_i.dv_step) begin
      dv_rem_q <= dv_ge ? 34'(dv_t - {1'b0, dv_den_q}) : dv_t[33:0];
      dv_quo_q <= {dv_quo_q[32:0], dv_ge};
    end
    if (cmd_i.dv_done) begin
      case (cmd_i.dv_sel)
        DV_N: begin
          n_q   <= dv_quo_q;
          cut_q <= dv_quo_q >= 34'(MAX_POINTS);
          qdx_q <= '0;
          qdy_q <= '0;
          rdx_q <= '0;
          rdy_q <= '0;
          qax_q <= '0;
          qay_q <= '0;
          rax_q <= '0;
          ray_q <= '0;
          idx_q <= '0;
        end
        DV_X: begin
          qdx_q <= fq;
          rdx_q <= fr;
        end
        default: begin
          qdy_q <= fq;
          rdy_q <= fr;
        end
      endcase
    end
    if (cmd_i.pt_emit) begin
      xh_q     <= hx[38:16];
      yh_q     <= hy[38:16];
      pidx_q   <= 6'(idx_q);
      last_q   <= sts_o.last_pt;
      status_q <= cut_q;
      idx_q    <= idx_q + IDX_W'(1);
      rax_q    <= wx ? 34'(tx - {1'b0, n_q}) : tx[33:0];
      ray_q    <= wy ? 34'(ty - {1'b0, n_q}) : ty[33:0];
      qax_q    <= qax_q + qdx_q + (wx ? 34'sd1 : 34'sd0);
      qay_q    <= qay_q + qdy_q + (wy ? 34'sd1 : 34'sd0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign x_hundredths_o = xh_q;
  assign y_hundredths_o = yh_q;
  assign point_index_o  = pidx_q;
  assign last_o         = last_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

// ----- design/segment_point_subdivider.sv -----
// Segment point subdivider: usage notes below.
// Depends on sps_pkg, the channel interfaces, sps_ctrl, sps_dp and assert_macros.svh.
//
// Channels: seg_i takes one segment per beat (Q16.16 start and end points);
// pt_o gives one point per beat, x and y in hundredths, its index in the run,
// a last flag and a status flag that is set on every point of a cut run.
// cfg_i writes the pitch register; it is always ready and must only be
// written while the block is idle.
// Flow: after a segment beat the block squares the differences (shift-add),
// takes the root (one bit per step), divides the root by the pitch and then
// both differences by the count on the shared restoring divider, and skips
// the two difference divisions when the count is zero. Points then leave
// one per cycle while pt_o is ready, up to 64 of them.
// A segment of all-zero coordinates is dropped in its accept cycle.
// seg_i is ready only between runs; the next segment is taken while the
// last point of a run still sits in the output register.
// A stall on pt_o holds the current point and freezes the point stepper.
// Reset (rst_ni low, asynchronous) empties the output, returns the
// controller to idle and sets the pitch to 1.0.
`default_nettype none
`include "assert_macros.svh"

module segment_point_subdivider import sps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sps_seg_if.sink   seg_i,
  sps_pt_if.source  pt_o,
  sps_cfg_if.sink   cfg_i
);

  sps_cmd_t cmd;
  sps_sts_t sts;

  // Pitch writes land at once; keeping them to idle periods is up to the user, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  sps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (seg_i.valid),
    .in_ready_o (seg_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .x_start_i      (seg_i.x_start),
    .y_start_i      (seg_i.y_start),
    .x_end_i        (seg_i.x_end),
    .y_end_i        (seg_i.y_end),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (pt_o.ready),
    .out_valid_o    (pt_o.valid),
    .x_hundredths_o (pt_o.x_hundredths),
    .y_hundredths_o (pt_o.y_hundredths),
    .point_index_o  (pt_o.point_index),
    .last_o         (pt_o.last),
    .status_o       (pt_o.status)
  );

  // A point is loaded only into a free output register
  `SPS_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd.pt_emit, sts.out_free)
  // No point leaves the stepper while waiting for a segment
  `SPS_ASSERT_IMPL(a_no_emit_idle, clk_i, rst_ni, seg_i.ready, !cmd.pt_emit)
  // A non-null segment beat starts a run that blocks further segments
  `SPS_ASSERT_NEXT(a_run_busy, clk_i, rst_ni,
                   seg_i.valid && seg_i.ready && !sts.zero_seg, !seg_i.ready)

endmodule

`default_nettype wire

// ----- tb/sv/tb_segment_point_subdivider.sv -----
// Testbench for segment_point_subdivider: drives segments, checks every point beat.
// Depends on sps_pkg, the sps_seg_if, sps_pt_if and sps_cfg_if interfaces, and the RTL.
`timescale 1ns / 100ps

module tb_segment_point_subdivider;
  import sps_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int SETTLE_CYCLES = 260;  // longest segment latency plus margin

  typedef struct packed {
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] xe;
    logic signed [31:0] ye;
  } segment_t;

  typedef struct packed {
    logic signed [22:0] x;
    logic signed [22:0] y;
    logic [5:0]         idx;
    logic               last;
    logic               status;
  } point_t;

  logic clk_i;
  logic rst_ni;

  sps_seg_if seg ();
  sps_pt_if  pt ();
  sps_cfg_if cfg ();

  segment_point_subdivider dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg),
    .pt_o   (pt),
    .cfg_i  (cfg)
  );

  // Points still owed by the block, oldest first, and our copy of the pitch.
  point_t      pending_points[$];
  logic [30:0] pitch_shadow;

  int  fail_count;
  int  mismatch_count;
  bit  idle_enable;
  int  long_hold_request;  // cycles the receiver must hold off, picked up by the ready driver

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("[segment_point_subdivider] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact floor of the length: largest r with r*r <= dx^2 + dy^2.
  function automatic logic [33:0] length_floor(logic [32:0] ax, logic [32:0] ay);
    logic [67:0] sum_sq;
    logic [67:0] cand;
    logic [33:0] root;
    sum_sq = {35'd0, ax} * {35'd0, ax} + {35'd0, ay} * {35'd0, ay};
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = {34'd0, root | (34'd1 << b)};
      if (cand * cand <= sum_sq) root = cand[33:0];
    end
    return root;
  endfunction

  // Division rounding toward minus infinity for a positive divisor.
  function automatic longint floor_quot(longint num, longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // Q16.16 coordinate to floored hundredths; arithmetic shift floors.
  function automatic logic signed [22:0] to_hundredths(longint q16);
    longint scaled;
    scaled = (q16 * 100) >>> 16;
    return scaled[22:0];
  endfunction

  task automatic predict_points(segment_t s);
    longint dx, dy, ax, ay, n, count, px, py;
    logic [33:0] root;
    logic [30:0] p;
    point_t pnt;
    if (s.xs == 0 && s.ys == 0 && s.xe == 0 && s.ye == 0) return;  // null segment: nothing out
    dx = longint'(s.xe) - longint'(s.xs);
    dy = longint'(s.ye) - longint'(s.ys);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    p = (pitch_shadow == 0) ? 31'd1 : pitch_shadow;  // zero pitch behaves as one
    root = length_floor(ax[32:0], ay[32:0]);
    n = longint'(root) / longint'(p);
    count = (n >= MAX_POINTS) ? MAX_POINTS : n + 1;
    for (longint i = 0; i < count; i++) begin
      px = s.xs;
      py = s.ys;
      if (n != 0) begin
        px = s.xs + floor_quot(i * dx, n);
        py = s.ys + floor_quot(i * dy, n);
      end
      pnt.x      = to_hundredths(px);
      pnt.y      = to_hundredths(py);
      pnt.idx    = i[5:0];
      pnt.last   = (i + 1 == count);
      pnt.status = (n >= MAX_POINTS);
      pending_points.push_back(pnt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    pt.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_request > 0) begin
        hold_left = long_hold_request;
        long_hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pt.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        pt.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 5);  // random length for the rest of the stall burst
        pt.ready <= 1'b0;
      end else begin
        pt.ready <= 1'b1;
      end
    end
  end

  // Check each point beat against the oldest pending point.
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && pt.valid && pt.ready) begin
      if (pending_points.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected point beat: x=%0d y=%0d idx=%0d", pt.x_hundredths,
                   pt.y_hundredths, pt.point_index);
      end else begin
        want = pending_points.pop_front();
        if (pt.x_hundredths !== want.x || pt.y_hundredths !== want.y ||
            pt.point_index !== want.idx || pt.last !== want.last ||
            pt.status !== want.status) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("point mismatch: exp x=%0d y=%0d idx=%0d last=%b st=%b, got x=%0d y=%0d idx=%0d last=%b st=%b",
                     want.x, want.y, want.idx, want.last, want.status, pt.x_hundredths,
                     pt.y_hundredths, pt.point_index, pt.last, pt.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // Offer one segment and hold it until accepted; valid stays high afterwards.
  task automatic send_segment(segment_t s);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      seg.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    seg.valid   <= 1'b1;
    seg.x_start <= s.xs;
    seg.y_start <= s.ys;
    seg.x_end   <= s.xe;
    seg.y_end   <= s.ye;
    @(posedge clk_i);
    while (!seg.ready) @(posedge clk_i);
    predict_points(s);
  endtask

  task automatic wait_drained();
    seg.valid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the pitch only while idle.
  task automatic write_pitch(logic [30:0] value);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
    pitch_shadow = value;
  endtask

  function automatic segment_t make_seg(int xs, int ys, int xe, int ye);
    segment_t s;
    s.xs = xs;
    s.ys = ys;
    s.xe = xe;
    s.ye = ye;
    return s;
  endfunction

  // Segment of roughly k pitches, random start and direction; 1 in 8 is raw noise.
  function automatic segment_t random_segment();
    segment_t s;
    longint span, dx, dy, xe, ye;
    s.xs = $urandom;
    s.ys = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      s.xe = $urandom;
      s.ye = $urandom;
      return s;
    end
    span = longint'(pitch_shadow == 0 ? 1 : pitch_shadow) * $urandom_range(0, 70);
    dx = (longint'($urandom_range(0, 65536)) * span) >>> 16;
    dy = (longint'($urandom_range(0, 65536)) * span) >>> 16;
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    xe = s.xs + dx;
    ye = s.ys + dy;
    s.xe = xe[31:0];
    s.ye = ye[31:0];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_special_segments();
    send_segment(make_seg(0, 0, 0, 0));                    // null segment: dropped
    send_segment(make_seg(32'h0001_8000, -32'sd5, 32'h0001_8000, -32'sd5));  // zero length
    send_segment(make_seg(0, 0, 32'h0000_8000, 0));        // shorter than the pitch
    send_segment(make_seg(0, 0, 63 * 65536, 0));           // 64 points, not cut
    send_segment(make_seg(0, 0, 0, 64 * 65536));           // just long enough to cut
    send_segment(make_seg(-100, 7, -100 - 5 * 65536, 7 - 3 * 65536));  // negative floors
    send_segment(make_seg(3 * 65536 + 1, -2, -65536, 4 * 65536 + 9));
  endtask

  task automatic test_field_extremes();
    send_segment(make_seg(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_segment(make_seg(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff));
    send_segment(make_seg(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_segment(make_seg(-1, -1, 0, 0));
    send_segment(make_seg(0, 0, -1, -1));
  endtask

  task automatic test_pitch_extremes();
    write_pitch(31'h7fff_ffff);                            // at most three points per segment
    send_segment(make_seg(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_segment(make_seg(0, 0, 32'sh7fff_ffff, 0));
    write_pitch(31'd1);                                    // pitch of one: a length of 100 is cut, one of 63 is not
    send_segment(make_seg(0, 0, 100, 0));
    send_segment(make_seg(5, 5, 5 + 63, 5));
    write_pitch(31'd0);                                    // zero pitch behaves as one
    send_segment(make_seg(0, 0, 0, 63));
    send_segment(make_seg(10, 10, 10, -60));
  endtask

  task automatic test_random_at(logic [30:0] p, int items);
    write_pitch(p);
    repeat (items) send_segment(random_segment());
  endtask

  // Hold the receiver off while segments keep coming, so the input stalls.
  task automatic test_output_stall();
    wait_drained();
    long_hold_request = 600;
    repeat (8) send_segment(random_segment());
  endtask

  // Pause the sender until every pending point is out, then resume.
  task automatic test_sender_pause();
    repeat (5) send_segment(random_segment());
    seg.valid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (5) send_segment(random_segment());
  endtask

  initial begin
    fail_count = 0;
    mismatch_count = 0;
    idle_enable = 1'b1;
    long_hold_request = 0;
    pitch_shadow = 31'd65536;
    seg.valid = 1'b0;
    seg.x_start = '0;
    seg.y_start = '0;
    seg.x_end = '0;
    seg.y_end = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_segments();
    test_field_extremes();
    test_pitch_extremes();
    test_random_at(31'd65536, 40);
    test_output_stall();
    test_random_at(31'd3 * 31'd65536 + 31'd12345, 35);
    test_sender_pause();
    test_random_at(31'($urandom_range(1, 32'h7fff_ffff)), 20);
    idle_enable = 1'b0;                                    // last stretch runs flat out
    test_random_at(31'd40000, 45);

    wait_drained();
    if (fail_count == 0) begin
      $display("[segment_point_subdivider] OK");
    end else begin
      $display("[segment_point_subdivider] ERROR");
    end
    $finish;
  end

endmodule
